@@ sv/spr_pkg.sv @@
// ----------------------------------------------------------------------------
// Sprite frame sequencer package
// Shared widths, reset values, register indexes, sequencer states and the
// request and response groups of the shared divider.
// ----------------------------------------------------------------------------
`default_nettype none

package spr_pkg;

  localparam int TimeBits    = 24;
  localparam int ElapsedBits = TimeBits + 1;
  localparam int FrameBits   = 12;
  localparam int CountBits   = 13;
  localparam int PixBits     = 15;
  localparam int SrcYBits    = 26;
  localparam int DivBits     = ElapsedBits;
  localparam int DivisorBits = TimeBits;
  localparam int DivCntBits  = 5;
  localparam int MulABits    = CountBits;
  localparam int MulBBits    = TimeBits;
  localparam int MulPBits    = MulABits + MulBBits;
  localparam int CfgIdxBits  = 3;
  localparam int CfgDataBits = 24;
  localparam int OutDataBits = 88;
  localparam int OutUserBits = 2;

  localparam logic [CountBits-1:0]  MaxFrames     = 13'd4096;
  localparam logic [TimeBits-1:0]   DurReset      = 24'd1000;
  localparam logic [CountBits-1:0]  CountReset    = 13'd1;
  localparam logic [PixBits-1:0]    CellReset     = 15'd1;
  localparam logic [DivCntBits-1:0] DivStepsTime  = 5'd25;
  localparam logic [DivCntBits-1:0] DivStepsSheet = 5'd15;
  localparam logic [DivCntBits-1:0] DivStepsFrame = 5'd12;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_FRAME_DURATION = 3'd0,
    REG_FRAME_COUNT    = 3'd1,
    REG_LOOP_ENABLE    = 3'd2,
    REG_SHEET_WIDTH    = 3'd3,
    REG_CELL_WIDTH     = 3'd4,
    REG_CELL_HEIGHT    = 3'd5,
    REG_SHEET_PRESENT  = 3'd6
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_T,
    ST_DIV_M,
    ST_MUL_N,
    ST_SUB_N,
    ST_RECT,
    ST_DIV_P,
    ST_DIV_R,
    ST_MUL_X,
    ST_MUL_Y,
    ST_LOAD_Y,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic                   start;
    logic [DivCntBits-1:0]  nbits;
    logic [DivBits-1:0]     dividend;
    logic [DivisorBits-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                   busy;
    logic                   done;
    logic [DivBits-1:0]     quot;
    logic [DivisorBits-1:0] rem;
  } div_rsp_t;

endpackage

`default_nettype wire

@@ sv/sprite_frame_sequencer.sv @@
// ----------------------------------------------------------------------------
// Sprite frame sequencer
// Animation frame timer for a sprite sheet with source rectangle output.
// ----------------------------------------------------------------------------
//   Channel   Direction  Contents
//   s_axis    in         tuser: command; tdata: delta_time
//   m_axis    out        tdata: frame and rectangle; tuser: done, rect valid
//   cfg       in         register write, index and data
//
// A word passes through up to four divisions of 25, 25, 15 and 12 steps in
// the shared divider, one quotient bit per cycle; a reset command with no
// sheet present uses none of them.
// Reset clears the animation state and loads the register reset values.
// A result waiting at the output holds the next word only at its final step.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_frame_sequencer (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [spr_pkg::TimeBits-1:0]    s_axis_tdata,  // delta_time
  input  wire logic                            s_axis_tuser,  // command
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // frame_index, src_x, src_y, src_w, src_h, zero fill
  output logic [spr_pkg::OutDataBits-1:0]      m_axis_tdata,
  output logic [spr_pkg::OutUserBits-1:0]      m_axis_tuser,  // done_flag, rect_valid
  input  wire logic                            cfg_we_i,
  input  wire logic [spr_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  wire logic [spr_pkg::CfgDataBits-1:0] cfg_data_i
);

  localparam int EB = spr_pkg::ElapsedBits;
  localparam int FB = spr_pkg::FrameBits;
  localparam int CB = spr_pkg::CountBits;
  localparam int PB = spr_pkg::PixBits;
  localparam int YB = spr_pkg::SrcYBits;
  localparam int DB = spr_pkg::DivBits;
  localparam int VB = spr_pkg::DivisorBits;

  spr_pkg::state_e state_q, state_d;

  logic [spr_pkg::TimeBits-1:0] dur_q;
  logic [CB-1:0] fcnt_q;
  logic          loop_q;
  logic [PB-1:0] sheet_w_q, cell_w_q, cell_h_q;
  logic          present_q;

  logic [EB-1:0] elapsed_q, elapsed_d;
  logic [FB-1:0] frame_q, frame_d;
  logic          fin_q, fin_d;
  logic [FB-1:0] row_q, row_d, col_q, col_d;
  logic [PB-1:0] sx_q, sx_d;
  logic [YB-1:0] sy_q, sy_d;
  logic          m_valid_q, m_valid_d;
  logic [spr_pkg::OutDataBits-1:0] out_data_q, out_data_d;
  logic [spr_pkg::OutUserBits-1:0] out_user_q, out_user_d;

  spr_pkg::div_req_t div_req;
  spr_pkg::div_rsp_t div_rsp;
  logic [spr_pkg::MulABits-1:0] mul_a;
  logic [spr_pkg::MulBBits-1:0] mul_b;
  logic [spr_pkg::MulPBits-1:0] prod;

  logic                         accept;
  logic [spr_pkg::TimeBits-1:0] dur_eff;
  logic [CB-1:0]                cnt_eff;
  logic                         skip;
  logic [EB:0]                  sum;
  logic [EB-1:0]                e_new;
  logic [CB-1:0]                frame_ext;
  logic                         beyond;
  logic [CB-1:0]                need;
  logic                         reach;
  logic [CB-1:0]                mod_sum;
  logic                         rect_ok;
  logic                         out_free;

  spr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  spr_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  always_comb begin
    s_axis_tready = (state_q == spr_pkg::ST_IDLE);
    accept        = s_axis_tvalid && s_axis_tready;
    dur_eff       = (dur_q == '0) ? spr_pkg::TimeBits'(1) : dur_q;
    cnt_eff       = (fcnt_q > spr_pkg::MaxFrames) ? spr_pkg::MaxFrames : fcnt_q;
    skip          = fin_q || !present_q || (cnt_eff <= CB'(1));
    sum           = {1'b0, elapsed_q} + {2'b00, s_axis_tdata};
    e_new         = sum[EB] ? {EB{1'b1}} : sum[EB-1:0];
    frame_ext     = {1'b0, frame_q};
    beyond        = frame_ext >= cnt_eff;
    need          = ((frame_ext + CB'(1)) >= cnt_eff) ? CB'(1) : (cnt_eff - frame_ext);
    reach         = div_rsp.quot >= {{(DB-CB){1'b0}}, need};
    mod_sum       = frame_ext + div_rsp.rem[CB-1:0];
    rect_ok       = present_q && (cell_w_q != '0) && (sheet_w_q >= cell_w_q);
    out_free      = !m_valid_q || m_axis_tready;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      spr_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = (s_axis_tuser || skip) ? spr_pkg::ST_RECT : spr_pkg::ST_DIV_T;
        end
      end
      spr_pkg::ST_DIV_T: begin
        if (div_rsp.done) begin
          if (div_rsp.quot == '0) begin
            state_d = spr_pkg::ST_RECT;
          end else if (loop_q) begin
            state_d = spr_pkg::ST_DIV_M;
          end else if (reach) begin
            state_d = spr_pkg::ST_MUL_N;
          end else begin
            state_d = spr_pkg::ST_RECT;
          end
        end
      end
      spr_pkg::ST_DIV_M: begin
        if (div_rsp.done) begin
          state_d = spr_pkg::ST_RECT;
        end
      end
      spr_pkg::ST_MUL_N: state_d = spr_pkg::ST_SUB_N;
      spr_pkg::ST_SUB_N: state_d = spr_pkg::ST_RECT;
      spr_pkg::ST_RECT: state_d = rect_ok ? spr_pkg::ST_DIV_P : spr_pkg::ST_OUT;
      spr_pkg::ST_DIV_P: begin
        if (div_rsp.done) begin
          state_d = spr_pkg::ST_DIV_R;
        end
      end
      spr_pkg::ST_DIV_R: begin
        if (div_rsp.done) begin
          state_d = spr_pkg::ST_MUL_X;
        end
      end
      spr_pkg::ST_MUL_X: state_d = spr_pkg::ST_MUL_Y;
      spr_pkg::ST_MUL_Y: state_d = spr_pkg::ST_LOAD_Y;
      spr_pkg::ST_LOAD_Y: state_d = spr_pkg::ST_OUT;
      spr_pkg::ST_OUT: begin
        if (out_free) begin
          state_d = spr_pkg::ST_IDLE;
        end
      end
      default: state_d = spr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    elapsed_d  = elapsed_q;
    frame_d    = frame_q;
    fin_d      = fin_q;
    row_d      = row_q;
    col_d      = col_q;
    sx_d       = sx_q;
    sy_d       = sy_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    out_data_d = out_data_q;
    out_user_d = out_user_q;
    div_req    = '0;
    mul_a      = '0;
    mul_b      = '0;
    case (state_q)
      spr_pkg::ST_IDLE: begin
        if (accept) begin
          if (s_axis_tuser) begin
            elapsed_d = '0;
            frame_d   = '0;
            fin_d     = 1'b0;
          end else if (!skip) begin
            elapsed_d        = e_new;
            div_req.start    = 1'b1;
            div_req.nbits    = spr_pkg::DivStepsTime;
            div_req.dividend = e_new;
            div_req.divisor  = dur_eff;
          end
        end
      end
      spr_pkg::ST_DIV_T: begin
        if (div_rsp.done && (div_rsp.quot != '0)) begin
          if (loop_q) begin
            elapsed_d        = {1'b0, div_rsp.rem};
            div_req.start    = 1'b1;
            div_req.nbits    = spr_pkg::DivStepsTime;
            div_req.dividend = beyond ? (div_rsp.quot - DB'(1)) : div_rsp.quot;
            div_req.divisor  = {{(VB-CB){1'b0}}, cnt_eff};
          end else if (!reach) begin
            frame_d   = frame_q + div_rsp.quot[FB-1:0];
            elapsed_d = {1'b0, div_rsp.rem};
          end
        end
      end
      spr_pkg::ST_DIV_M: begin
        if (div_rsp.done) begin
          if (beyond) begin
            frame_d = div_rsp.rem[FB-1:0];
          end else if (mod_sum >= cnt_eff) begin
            frame_d = FB'(mod_sum - cnt_eff);
          end else begin
            frame_d = mod_sum[FB-1:0];
          end
        end
      end
      spr_pkg::ST_MUL_N: begin
        mul_a = need;
        mul_b = dur_eff;
      end
      spr_pkg::ST_SUB_N: begin
        elapsed_d = elapsed_q - prod[EB-1:0];
        frame_d   = FB'(cnt_eff - CB'(1));
        fin_d     = 1'b1;
      end
      spr_pkg::ST_RECT: begin
        if (!rect_ok) begin
          sx_d = '0;
          sy_d = '0;
        end else begin
          div_req.start    = 1'b1;
          div_req.nbits    = spr_pkg::DivStepsSheet;
          div_req.dividend = {{(DB-PB){1'b0}}, sheet_w_q};
          div_req.divisor  = {{(VB-PB){1'b0}}, cell_w_q};
        end
      end
      spr_pkg::ST_DIV_P: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.nbits    = spr_pkg::DivStepsFrame;
          div_req.dividend = {{(DB-FB){1'b0}}, frame_q};
          div_req.divisor  = {{(VB-PB){1'b0}}, div_rsp.quot[PB-1:0]};
        end
      end
      spr_pkg::ST_DIV_R: begin
        if (div_rsp.done) begin
          row_d = div_rsp.quot[FB-1:0];
          col_d = div_rsp.rem[FB-1:0];
        end
      end
      spr_pkg::ST_MUL_X: begin
        mul_a = {1'b0, col_q};
        mul_b = {{(spr_pkg::MulBBits-PB){1'b0}}, cell_w_q};
      end
      spr_pkg::ST_MUL_Y: begin
        sx_d  = prod[PB-1:0];
        mul_a = {1'b0, row_q};
        mul_b = {{(spr_pkg::MulBBits-PB){1'b0}}, cell_h_q};
      end
      spr_pkg::ST_LOAD_Y: begin
        sy_d = prod[YB-1:0];
      end
      spr_pkg::ST_OUT: begin
        if (out_free) begin
          m_valid_d  = 1'b1;
          out_data_d = {5'd0, cell_h_q, cell_w_q, sy_q, sx_q, frame_q};
          out_user_d = {rect_ok, fin_q};
        end
      end
      default: begin
        m_valid_d = m_valid_q && !m_axis_tready;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= spr_pkg::ST_IDLE;
      elapsed_q <= '0;
      frame_q   <= '0;
      fin_q     <= 1'b0;
      m_valid_q <= 1'b0;
      dur_q     <= spr_pkg::DurReset;
      fcnt_q    <= spr_pkg::CountReset;
      loop_q    <= 1'b1;
      sheet_w_q <= '0;
      cell_w_q  <= spr_pkg::CellReset;
      cell_h_q  <= spr_pkg::CellReset;
      present_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      elapsed_q <= elapsed_d;
      frame_q   <= frame_d;
      fin_q     <= fin_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        case (spr_pkg::cfg_idx_e'(cfg_index_i))
          spr_pkg::REG_FRAME_DURATION: dur_q     <= cfg_data_i;
          spr_pkg::REG_FRAME_COUNT:    fcnt_q    <= cfg_data_i[CB-1:0];
          spr_pkg::REG_LOOP_ENABLE:    loop_q    <= cfg_data_i[0];
          spr_pkg::REG_SHEET_WIDTH:    sheet_w_q <= cfg_data_i[PB-1:0];
          spr_pkg::REG_CELL_WIDTH:     cell_w_q  <= cfg_data_i[PB-1:0];
          spr_pkg::REG_CELL_HEIGHT:    cell_h_q  <= cfg_data_i[PB-1:0];
          spr_pkg::REG_SHEET_PRESENT:  present_q <= cfg_data_i[0];
          default: begin
            present_q <= present_q;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    row_q      <= row_d;
    col_q      <= col_d;
    sx_q       <= sx_d;
    sy_q       <= sy_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

`ifndef NO_ASSERTIONS
  a_idle_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == spr_pkg::ST_IDLE) |-> !div_rsp.busy)
    else $error("divider still busy while the sequencer is idle");

  a_finished_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_q && (state_q != spr_pkg::ST_IDLE)) |=> $stable(frame_q))
    else $error("frame moved after the one-shot animation finished");

  a_invalid_rect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[1]) |-> (m_axis_tdata[52:12] == '0))
    else $error("invalid rectangle carries nonzero coordinates");
`endif

endmodule

`default_nettype wire

@@ sv/spr_div.sv @@
// ----------------------------------------------------------------------------
// Sprite sequencer divider
// Restoring divider shared by all divisions, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module spr_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire spr_pkg::div_req_t req_i,
  output spr_pkg::div_rsp_t      rsp_o
);

  logic                            busy_q, busy_d;
  logic [spr_pkg::DivCntBits-1:0]  cnt_q, cnt_d;
  logic [spr_pkg::DivBits-1:0]     quot_q, quot_d;
  logic [spr_pkg::DivisorBits-1:0] rem_q, rem_d;
  logic [spr_pkg::DivisorBits-1:0] dvs_q, dvs_d;
  logic [spr_pkg::DivBits-1:0]     trial;
  logic [spr_pkg::DivBits-1:0]     diff;
  logic [spr_pkg::DivCntBits-1:0]  shamt;
  logic                            fits;

  always_comb begin
    trial = {rem_q, quot_q[spr_pkg::DivBits-1]};
    fits  = trial >= {1'b0, dvs_q};
    diff  = trial - {1'b0, dvs_q};
    shamt = spr_pkg::DivCntBits'(spr_pkg::DivBits) - req_i.nbits;
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.nbits;
      quot_d = req_i.dividend << shamt;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        cnt_d  = cnt_q - 1'b1;
        rem_d  = fits ? diff[spr_pkg::DivisorBits-1:0] : trial[spr_pkg::DivisorBits-1:0];
        quot_d = {quot_q[spr_pkg::DivBits-2:0], fits};
      end else begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = busy_q && (cnt_q == '0);
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q;

endmodule

`default_nettype wire

@@ sv/spr_mul.sv @@
// ----------------------------------------------------------------------------
// Sprite sequencer multiplier
// Registered multiplier shared by the time and rectangle products.
// ----------------------------------------------------------------------------
`default_nettype none

module spr_mul (
  input  wire logic                         clk_i,
  input  wire logic [spr_pkg::MulABits-1:0] a_i,
  input  wire logic [spr_pkg::MulBBits-1:0] b_i,
  output logic      [spr_pkg::MulPBits-1:0] p_o
);

  logic [spr_pkg::MulPBits-1:0] p_q, p_d;

  assign p_d = {{spr_pkg::MulBBits{1'b0}}, a_i} * {{spr_pkg::MulABits{1'b0}}, b_i};

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

`default_nettype wire
